### hw/rtl/csd_pkg.sv
// Shared constants, state encoding and a helper function for the closest segment distance block.
`default_nettype none
package csd_pkg;
   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int MAG_W     = COORD_W + 2;
   localparam int PROD_W    = 2 * MAG_W;
   localparam int WIDE_W    = PROD_W + 1;
   localparam int T_W       = 32;
   localparam int ROOT_W    = PROD_W / 2;
   localparam int DIST_W    = FRAC_BITS + 14;
   localparam int CMP_W     = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;
   localparam int CNT_W     = $clog2(MAG_W + 1);
   localparam logic [DIST_W-1:0] DIST_CAP = DIST_W'(10000) << FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROD, ST_PRODW, ST_SUM, ST_CHOOSE, ST_DIVW, ST_SCALE, ST_SCALEW,
      ST_ROUND, ST_ERR, ST_FSQ, ST_FSQW, ST_VSUM, ST_SQRTW, ST_FIN
   } state_type;

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W:0] v);
      logic signed [MAG_W:0] a;
      a = v[MAG_W] ? -v : v;
      return a[MAG_W-1:0];
   endfunction
endpackage
`default_nettype wire

### hw/rtl/closest_segment_distance.sv
// Top level: smallest distance from a query point to a run of 2-D segments.
// An item whose nearest point is an endpoint goes from the segment products straight to the error
// multiplies and the root; an interior projection first runs the division and the scaling
// multiplies. One item is worked on at a time, so a new item is taken only once the last is done,
// and not while a closing item waits on a stalled result.
// After reset the running minimum is 10000 and no result is pending.
`default_nettype none
module closest_segment_distance (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [31:0]          req_point_x,
   input  wire logic signed [31:0]          req_point_y,
   input  wire logic signed [31:0]          req_start_x,
   input  wire logic signed [31:0]          req_start_y,
   input  wire logic signed [31:0]          req_end_x,
   input  wire logic signed [31:0]          req_end_y,
   input  wire logic                        req_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [csd_pkg::DIST_W-1:0]       rsp_min_distance
);
   import csd_pkg::*;

   state_type state_ff, state_in;

   // Item registers, captured when the item is accepted.
   logic signed [COORD_W-1:0] px_ff, py_ff, sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [DIFF_W-1:0]  ax_ff, ay_ff, dx_ff, dy_ff;
   logic                      last_ff;

   // Intermediate results.
   logic signed [WIDE_W-1:0]  dot_ff, dot_in;
   logic [WIDE_W-1:0]         len2_ff, len2_in;
   logic signed [MAG_W-1:0]   qx_ff, qy_ff, qx_in, qy_in;
   logic [MAG_W-1:0]          fxm_ff, fym_ff, fxm_in, fym_in;
   logic [DIST_W-1:0]         min_ff, newmin;
   logic                      rsp_valid_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;

   logic [MAG_W-1:0]  amx, amy, dmx, dmy, tx;
   logic [MAG_W-1:0]  op_a [4];
   logic [MAG_W-1:0]  op_b [4];
   logic [PROD_W-1:0] prod [4];
   logic [3:0]        mul_busy;
   logic              mul_load, mul_load4, div_load, sqrt_load, div_busy, sqrt_busy;
   logic [T_W-1:0]    t;
   logic [ROOT_W-1:0] root;
   logic [PROD_W-1:0] vsum;

   logic signed [WIDE_W-1:0] s0, s1;
   logic                     near_start, at_end, out_free, accept;
   logic [PROD_W-1:0]        rx, ry;
   logic signed [MAG_W:0]    offx, offy, sumx, sumy, fx, fy;
   logic [CMP_W-1:0]         root_ext, dist_ext;
   logic [DIST_W-1:0]        seg_dist;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Segment products and their signed sums.
   always_comb begin
      amy = mag_of((MAG_W+1)'(ay_ff));
      dmx = mag_of((MAG_W+1)'(dx_ff));
      dmy = mag_of((MAG_W+1)'(dy_ff));
      amx = mag_of((MAG_W+1)'(ax_ff));
      tx  = {{(MAG_W-T_W){1'b0}}, t};

      s0 = (ax_ff[DIFF_W-1] ^ dx_ff[DIFF_W-1]) ? -$signed({1'b0, prod[0]})
                                               : $signed({1'b0, prod[0]});
      s1 = (ay_ff[DIFF_W-1] ^ dy_ff[DIFF_W-1]) ? -$signed({1'b0, prod[1]})
                                               : $signed({1'b0, prod[1]});
      dot_in  = s0 + s1;
      len2_in = {1'b0, prod[2]} + {1'b0, prod[3]};
      vsum    = prod[0] + prod[1];

      near_start = (len2_ff == '0) || dot_ff[WIDE_W-1] || (dot_ff == '0);
      at_end     = ($unsigned(dot_ff) >= len2_ff);

      // Rounded offset along the segment, ties away from zero.
      rx   = prod[0] + (PROD_W'(1) << (T_W - 1));
      ry   = prod[1] + (PROD_W'(1) << (T_W - 1));
      offx = dx_ff[DIFF_W-1] ? -$signed({1'b0, rx[T_W +: MAG_W]}) : $signed({1'b0, rx[T_W +: MAG_W]});
      offy = dy_ff[DIFF_W-1] ? -$signed({1'b0, ry[T_W +: MAG_W]}) : $signed({1'b0, ry[T_W +: MAG_W]});
      sumx = (MAG_W+1)'(sx_ff) + offx;
      sumy = (MAG_W+1)'(sy_ff) + offy;

      fx     = (MAG_W+1)'(px_ff) - (MAG_W+1)'(qx_ff);
      fy     = (MAG_W+1)'(py_ff) - (MAG_W+1)'(qy_ff);
      fxm_in = mag_of(fx);
      fym_in = mag_of(fy);

      root_ext = CMP_W'(root);
      dist_ext = (root_ext > CMP_W'(DIST_CAP)) ? CMP_W'(DIST_CAP) : root_ext;
      seg_dist = dist_ext[DIST_W-1:0];
      newmin   = (seg_dist < min_ff) ? seg_dist : min_ff;
   end

   // Operand selection for the four serial multipliers.
   always_comb begin
      op_a[0] = amx; op_b[0] = dmx;
      op_a[1] = amy; op_b[1] = dmy;
      op_a[2] = dmx; op_b[2] = dmx;
      op_a[3] = dmy; op_b[3] = dmy;
      if (state_ff == ST_SCALE) begin
         op_a[0] = tx; op_b[0] = dmx;
         op_a[1] = tx; op_b[1] = dmy;
      end else if (state_ff == ST_FSQ) begin
         op_a[0] = fxm_ff; op_b[0] = fxm_ff;
         op_a[1] = fym_ff; op_b[1] = fym_ff;
      end
   end

   // Sequencer: next state and unit start strobes.
   always_comb begin
      state_in  = state_ff;
      mul_load  = 1'b0;
      mul_load4 = 1'b0;
      div_load  = 1'b0;
      sqrt_load = 1'b0;
      qx_in     = qx_ff;
      qy_in     = qy_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_PROD;
         ST_PROD: begin
            mul_load  = 1'b1;
            mul_load4 = 1'b1;
            state_in  = ST_PRODW;
         end
         ST_PRODW:  if (mul_busy == '0) state_in = ST_SUM;
         ST_SUM:    state_in = ST_CHOOSE;
         ST_CHOOSE: begin
            // The segment's first endpoint covers zero length and points behind it.
            if (near_start) begin
               qx_in    = MAG_W'(sx_ff);
               qy_in    = MAG_W'(sy_ff);
               state_in = ST_ERR;
            end else if (at_end) begin
               qx_in    = MAG_W'(ex_ff);
               qy_in    = MAG_W'(ey_ff);
               state_in = ST_ERR;
            end else begin
               div_load = 1'b1;
               state_in = ST_DIVW;
            end
         end
         ST_DIVW:   if (!div_busy) state_in = ST_SCALE;
         ST_SCALE: begin
            mul_load = 1'b1;
            state_in = ST_SCALEW;
         end
         ST_SCALEW: if (mul_busy[1:0] == 2'b00) state_in = ST_ROUND;
         ST_ROUND: begin
            qx_in    = sumx[MAG_W-1:0];
            qy_in    = sumy[MAG_W-1:0];
            state_in = ST_ERR;
         end
         ST_ERR:    state_in = ST_FSQ;
         ST_FSQ: begin
            mul_load = 1'b1;
            state_in = ST_FSQW;
         end
         ST_FSQW:   if (mul_busy[1:0] == 2'b00) state_in = ST_VSUM;
         ST_VSUM: begin
            sqrt_load = 1'b1;
            state_in  = ST_SQRTW;
         end
         ST_SQRTW:  if (!sqrt_busy) state_in = ST_FIN;
         ST_FIN: begin
            // A closing item waits here only while an earlier result is still held.
            if (!last_ff || out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Running minimum and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= DIST_CAP;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FIN && last_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_FIN) begin
            if (!last_ff) begin
               min_ff <= newmin;
            end else if (out_free) begin
               min_ff <= DIST_CAP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && last_ff && out_free) begin
         rsp_dist_ff <= newmin;
      end
      if (accept) begin
         px_ff   <= req_point_x;
         py_ff   <= req_point_y;
         sx_ff   <= req_start_x;
         sy_ff   <= req_start_y;
         ex_ff   <= req_end_x;
         ey_ff   <= req_end_y;
         last_ff <= req_last;
         ax_ff   <= DIFF_W'(req_point_x) - DIFF_W'(req_start_x);
         ay_ff   <= DIFF_W'(req_point_y) - DIFF_W'(req_start_y);
         dx_ff   <= DIFF_W'(req_end_x) - DIFF_W'(req_start_x);
         dy_ff   <= DIFF_W'(req_end_y) - DIFF_W'(req_start_y);
      end
      if (state_ff == ST_SUM) begin
         dot_ff  <= dot_in;
         len2_ff <= len2_in;
      end
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      if (state_ff == ST_ERR) begin
         fxm_ff <= fxm_in;
         fym_ff <= fym_in;
      end
   end

   csd_mul u_mul0 (.clock(clock), .reset(reset), .load(mul_load), .a(op_a[0]), .b(op_b[0]),
                   .busy(mul_busy[0]), .product(prod[0]));
   csd_mul u_mul1 (.clock(clock), .reset(reset), .load(mul_load), .a(op_a[1]), .b(op_b[1]),
                   .busy(mul_busy[1]), .product(prod[1]));
   csd_mul u_mul2 (.clock(clock), .reset(reset), .load(mul_load4), .a(op_a[2]), .b(op_b[2]),
                   .busy(mul_busy[2]), .product(prod[2]));
   csd_mul u_mul3 (.clock(clock), .reset(reset), .load(mul_load4), .a(op_a[3]), .b(op_b[3]),
                   .busy(mul_busy[3]), .product(prod[3]));

   csd_div u_div (.clock(clock), .reset(reset), .load(div_load), .num(dot_ff), .den(len2_ff),
                  .busy(div_busy), .quot(t));

   csd_sqrt u_sqrt (.clock(clock), .reset(reset), .load(sqrt_load), .v(vsum),
                    .busy(sqrt_busy), .root(root));

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_distance = rsp_dist_ff;
endmodule
`default_nettype wire

### hw/rtl/csd_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module csd_mul (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire logic [csd_pkg::MAG_W-1:0]  a,
   input  wire logic [csd_pkg::MAG_W-1:0]  b,
   output logic                            busy,
   output logic [csd_pkg::PROD_W-1:0]      product
);
   import csd_pkg::*;

   logic [MAG_W-1:0]  a_ff;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [MAG_W:0]    sum;

   always_comb begin
      sum    = {1'b0, acc_ff[PROD_W-1:MAG_W]} + (acc_ff[0] ? {1'b0, a_ff} : '0);
      acc_in = {sum, acc_ff[MAG_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= CNT_W'(MAG_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_ff   <= a;
         acc_ff <= {{MAG_W{1'b0}}, b};
      end else if (cnt_ff != '0) begin
         acc_ff <= acc_in;
      end
   end

   assign busy    = (cnt_ff != '0);
   assign product = acc_ff;
endmodule
`default_nettype wire

### hw/rtl/csd_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module csd_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire logic [csd_pkg::WIDE_W-1:0] num,
   input  wire logic [csd_pkg::WIDE_W-1:0] den,
   output logic                            busy,
   output logic [csd_pkg::T_W-1:0]         quot
);
   import csd_pkg::*;

   logic [WIDE_W-1:0] rem_ff, den_ff, shifted, rem_in;
   logic [T_W-1:0]    t_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              ge;

   always_comb begin
      shifted = {rem_ff[WIDE_W-2:0], 1'b0};
      ge      = (shifted >= den_ff);
      rem_in  = ge ? (shifted - den_ff) : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= CNT_W'(T_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= num;
         den_ff <= den;
         t_ff   <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         t_ff   <= {t_ff[T_W-2:0], ge};
      end
   end

   assign busy = (cnt_ff != '0);
   assign quot = t_ff;
endmodule
`default_nettype wire

### hw/rtl/csd_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none
module csd_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire logic [csd_pkg::PROD_W-1:0] v,
   output logic                            busy,
   output logic [csd_pkg::ROOT_W-1:0]      root
);
   import csd_pkg::*;

   localparam int REM_W = ROOT_W + 4;

   logic [PROD_W-1:0] src_ff;
   logic [REM_W-1:0]  rem_ff, rem_sh, trial, rem_in;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              ge;

   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], src_ff[PROD_W-1:PROD_W-2]};
      trial  = {2'b00, root_ff, 2'b01};
      ge     = (rem_sh >= trial);
      rem_in = ge ? (rem_sh - trial) : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= CNT_W'(ROOT_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         src_ff  <= v;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cnt_ff != '0) begin
         src_ff  <= {src_ff[PROD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= {root_ff[ROOT_W-2:0], ge};
      end
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;
endmodule
`default_nettype wire

### dv/closest_segment_distance_test.sv
// Testbench for the closest segment distance block: directed and random runs checked against a predictor.
`default_nettype none
module closest_segment_distance_test;
   timeunit 1ns;
   timeprecision 1ps;
   import csd_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [31:0] req_point_x, req_point_y;
   logic signed [31:0] req_start_x, req_start_y;
   logic signed [31:0] req_end_x, req_end_y;
   logic req_last;
   logic rsp_valid;
   logic rsp_stall;
   logic [DIST_W-1:0] rsp_min_distance;

   closest_segment_distance u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_min_distance(rsp_min_distance)
   );

   // Expected minimum distances, oldest first, and the predictor's own running minimum.
   logic [DIST_W-1:0] min_dist_q[$];
   logic [DIST_W-1:0] run_min;
   int mismatches;
   // When set, neither side idles, so back-to-back traffic is covered too.
   bit no_gaps;
   int stall_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A generous fixed limit for a run of about 850 items.
   initial begin
      #40ms;
      $display("closest_segment_distance_test: done, errors");
      $finish;
   end

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // Distance from the point to the nearest point of one segment, capped at 10000.
   function automatic logic [DIST_W-1:0] nearest_distance(
         input logic signed [31:0] px, input logic signed [31:0] py,
         input logic signed [31:0] sx, input logic signed [31:0] sy,
         input logic signed [31:0] ex, input logic signed [31:0] ey);
      logic signed [63:0] ax, ay, dx, dy, qx, qy, fx, fy;
      logic signed [127:0] dot, len2;
      logic [127:0] t, mx, my, v, r, c;
      ax = px - sx;
      ay = py - sy;
      dx = ex - sx;
      dy = ey - sy;
      dot = ax * dx + ay * dy;
      len2 = dx * dx + dy * dy;
      if (len2 == 0 || dot <= 0) begin
         qx = sx;
         qy = sy;
      end else if (dot >= len2) begin
         qx = ex;
         qy = ey;
      end else begin
         // Interior: a 32-bit projection parameter, then rounding half away from zero.
         t = (128'(dot) << 32) / 128'(len2);
         mx = (t * 128'(mag64(dx)) + (128'd1 << 31)) >> 32;
         my = (t * 128'(mag64(dy)) + (128'd1 << 31)) >> 32;
         qx = dx[63] ? 64'(sx) - 64'(mx) : 64'(sx) + 64'(mx);
         qy = dy[63] ? 64'(sy) - 64'(my) : 64'(sy) + 64'(my);
      end
      fx = px - qx;
      fy = py - qy;
      v = 128'(mag64(fx)) * 128'(mag64(fx)) + 128'(mag64(fy)) * 128'(mag64(fy));
      r = 0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= v) r = c;
      end
      if (r > 128'(DIST_CAP)) r = 128'(DIST_CAP);
      return r[DIST_W-1:0];
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Mostly moderate coordinates, some whole integers (ties and exact hits), some full range.
   function automatic logic signed [31:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return $urandom;
      if (r < 8) return int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      return (int'($urandom_range(0, 2000)) - 1000) <<< 16;
   endfunction

   // Sends one item after a random gap and updates the prediction once it is accepted.
   task automatic send_item(input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] sx, input logic signed [31:0] sy,
                            input logic signed [31:0] ex, input logic signed [31:0] ey,
                            input logic lst);
      int gap;
      logic [DIST_W-1:0] d;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_point_x <= px;
      req_point_y <= py;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      req_last <= lst;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      d = nearest_distance(px, py, sx, sy, ex, ey);
      if (d < run_min) run_min = d;
      if (lst) begin
         min_dist_q = {min_dist_q, run_min};
         run_min = DIST_CAP;
      end
   endtask

   // A run of n segments around one fixed point; some segments are zero length.
   task automatic send_run(input int n);
      logic signed [31:0] px, py, sx, sy;
      px = pick_coord();
      py = pick_coord();
      for (int i = 0; i < n; i++) begin
         sx = pick_coord();
         sy = pick_coord();
         if ($urandom_range(0, 9) == 0)
            send_item(px, py, sx, sy, sx, sy, i == n - 1);
         else
            send_item(px, py, sx, sy, pick_coord(), pick_coord(), i == n - 1);
      end
   endtask

   task automatic test_directed();
      localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
      localparam logic signed [31:0] MINC = 32'sh8000_0000;
      localparam logic signed [31:0] ONE = 32'sh0001_0000;
      // Extremes: point and segment at opposite corners, capped far-point distance.
      send_item(MAXC, MAXC, MINC, MINC, MINC, MINC, 1'b1);
      send_item(MINC, MAXC, MAXC, MINC, MINC, MINC, 1'b1);
      send_item(MINC, MINC, MAXC, MAXC, MINC, MAXC, 1'b1);
      send_item(MAXC, MINC, MINC, MAXC, MAXC, MAXC, 1'b1);
      send_item(0, 0, 0, 0, 0, 0, 1'b1);
      send_item(-1, -1, -1, -1, -1, -1, 1'b1);
      // Zero-length segment: the first endpoint is the nearest point.
      send_item(3 * ONE, 4 * ONE, 0, 0, 0, 0, 1'b1);
      // Projection before the start, past the end, and in the interior.
      send_item(-5 * ONE, ONE, 0, 0, 10 * ONE, 0, 1'b1);
      send_item(15 * ONE, ONE, 0, 0, 10 * ONE, 0, 1'b1);
      send_item(3 * ONE, 7 * ONE, 0, 0, 10 * ONE, 0, 1'b1);
      send_item(ONE + 1, ONE - 1, -7 * ONE, 3, 9 * ONE + 5, -11 * ONE, 1'b1);
      // A run where the minimum comes in the middle, then a point exactly on a segment.
      send_item(0, 0, 50 * ONE, 50 * ONE, 60 * ONE, 50 * ONE, 1'b0);
      send_item(0, 0, ONE, -ONE, ONE, ONE, 1'b0);
      send_item(0, 0, 20 * ONE, 0, 20 * ONE, 5 * ONE, 1'b1);
      send_item(2 * ONE, 2 * ONE, 0, 0, 4 * ONE, 4 * ONE, 1'b1);
      // Every segment far away: the minimum stays at the cap.
      send_item(MAXC, 0, MINC, MINC, MINC, MAXC, 1'b0);
      send_item(MAXC, 0, MINC, 0, MINC, 1, 1'b1);
   endtask

   task automatic test_random_runs(input int n_items);
      int sent, len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
         no_gaps = ($urandom_range(0, 7) == 0);
         send_run(len);
         sent += len;
      end
      no_gaps = 1'b0;
   endtask

   // Fully random fields, including a point that changes inside a run.
   task automatic test_noise(input int n_items);
      for (int i = 0; i < n_items; i++)
         send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   ($urandom_range(0, 2) == 0) || (i == n_items - 1));
   endtask

   // Result side: random stalls and an in-order check against the expected minima.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (min_dist_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: min_distance %0d", rsp_min_distance);
            end else begin
               if (rsp_min_distance !== min_dist_q[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("min_distance mismatch: expected %0d, actual %0d",
                              min_dist_q[0], rsp_min_distance);
               end
               void'(min_dist_q.pop_front());
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      mismatches = 0;
      no_gaps = 1'b0;
      stall_left = 0;
      run_min = DIST_CAP;
      reset = 1'b1;
      req_valid = 1'b0;
      req_point_x = 0;
      req_point_y = 0;
      req_start_x = 0;
      req_start_y = 0;
      req_end_x = 0;
      req_end_y = 0;
      req_last = 1'b0;
      rsp_stall = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_runs(700);
      test_noise(130);
      req_valid <= 1'b0;

      wait (min_dist_q.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && min_dist_q.size() == 0) begin
         $display("closest_segment_distance_test: done, clean");
      end else begin
         $display("closest_segment_distance_test: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
